FILE: design/complex_arithmetic_unit_top_assert.svh
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, port width and the per-item flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FIELD_BITS = 32;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic ovf;
    logic neg_re;
    logic neg_im;
    logic clamp_re;
    logic clamp_im;
  } flags_t;

endpackage

`default_nettype wire

FILE: design/complex_arithmetic_unit_top.sv
// Each transaction passes in order through the front-end stages, the divider steps and the output stage.
// Throughput: one transaction per cycle while out_stall is low; the divider is one stage per quotient bit.
// Each stage holds its item under stall and fills when empty, so bubbles collapse.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep values.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply and divide of Q-format complex numbers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_top_assert.svh"

module complex_arithmetic_unit_top #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_mode,
  input  wire logic [cau_pkg::FIELD_BITS-1:0]     in_a_real,
  input  wire logic [cau_pkg::FIELD_BITS-1:0]     in_a_imag,
  input  wire logic [cau_pkg::FIELD_BITS-1:0]     in_b_real,
  input  wire logic [cau_pkg::FIELD_BITS-1:0]     in_b_imag,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cau_pkg::FIELD_BITS-1:0]          out_res_real,
  output logic [cau_pkg::FIELD_BITS-1:0]          out_res_imag,
  output logic                                    out_overflow,
  output logic                                    out_div_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int DW = 2 * W + F;
  localparam int NS = W + 5;
  localparam int FB = cau_pkg::FIELD_BITS;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [FB-1:0] EMAX = FB'($signed(SMAX));
  localparam logic [FB-1:0] EMIN = FB'($signed(SMIN));

  // Valid bits and per-stage advance.
  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   rdy;

  assign rdy[NS] = !out_stall;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
      if (k == 0) begin : g_first
        assign v_nxt[k] = rdy[k] ? in_valid : v_r[k];
      end else begin : g_rest
        assign v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];

  // Front end.
  cau_pkg::flags_t flags_s [0:W+1];
  logic [W-1:0]    rre_s   [0:W+1];
  logic [W-1:0]    rim_s   [0:W+1];
  logic [DW-1:0]   rem_re_s[0:W+1];
  logic [DW-1:0]   rem_im_s[0:W+1];
  logic [W:0]      q_re_s  [0:W+1];
  logic [W:0]      q_im_s  [0:W+1];
  logic [2*W-1:0]  den_s   [0:W+1];

  cau_front #(.W(W), .F(F)) u_front (
    .clk      (clk),
    .en       (rdy[2:0]),
    .mode     (cau_pkg::mode_t'(in_mode)),
    .a_re     ($signed(in_a_real[W-1:0])),
    .a_im     ($signed(in_a_imag[W-1:0])),
    .b_re     ($signed(in_b_real[W-1:0])),
    .b_im     ($signed(in_b_imag[W-1:0])),
    .flags_r  (flags_s[0]),
    .res_re_r (rre_s[0]),
    .res_im_r (rim_s[0]),
    .rem_re_r (rem_re_s[0]),
    .rem_im_r (rem_im_s[0]),
    .den_r    (den_s[0])
  );

  assign q_re_s[0] = '0;
  assign q_im_s[0] = '0;

  // Long division, most significant quotient bit first.
  genvar j;
  generate
    for (j = 0; j <= W; j++) begin : g_div
      cau_div_step #(.W(W), .F(F), .BIT(W - j)) u_step (
        .clk       (clk),
        .en        (rdy[3+j]),
        .flags_in  (flags_s[j]),
        .res_re_in (rre_s[j]),
        .res_im_in (rim_s[j]),
        .rem_re_in (rem_re_s[j]),
        .rem_im_in (rem_im_s[j]),
        .q_re_in   (q_re_s[j]),
        .q_im_in   (q_im_s[j]),
        .den_in    (den_s[j]),
        .flags_r   (flags_s[j+1]),
        .res_re_r  (rre_s[j+1]),
        .res_im_r  (rim_s[j+1]),
        .rem_re_r  (rem_re_s[j+1]),
        .rem_im_r  (rem_im_s[j+1]),
        .q_re_r    (q_re_s[j+1]),
        .q_im_r    (q_im_s[j+1]),
        .den_r     (den_s[j+1])
      );
    end
  endgenerate

  cau_out #(.W(W)) u_out (
    .clk           (clk),
    .en            (rdy[NS-1]),
    .flags         (flags_s[W+1]),
    .res_re        (rre_s[W+1]),
    .res_im        (rim_s[W+1]),
    .q_re          (q_re_s[W+1]),
    .q_im          (q_im_s[W+1]),
    .res_real_r    (out_res_real),
    .res_imag_r    (out_res_imag),
    .overflow_r    (out_overflow),
    .div_by_zero_r (out_div_by_zero)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_div_by_zero, (out_res_real == '0) && (out_res_imag == '0) && !out_overflow, "division by zero result not cleared")
  `CAU_ASSERT_IMP(a_ovf_sat, out_valid && out_overflow, (out_res_real == EMAX) || (out_res_real == EMIN) || (out_res_imag == EMAX) || (out_res_imag == EMIN), "overflow without a saturated part")
  `CAU_ASSERT_IMP(a_full_stall, out_valid && out_stall && (&v_r), in_stall, "full stalled pipeline took a transaction")
  `CAU_ASSERT_IMP(a_stall_reason, in_stall, v_r[0], "input stalled with an empty first stage")
  `CAU_ASSERT_NXT(a_count, 1'b1, $countones(v_r) == ($past($countones(v_r)) + int'($past(in_acc)) - int'($past(out_acc))), "transaction count mismatch")

endmodule

`default_nettype wire

FILE: design/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: products, combination, saturation or divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic [2:0]            en,
  input  wire cau_pkg::mode_t        mode,
  input  wire logic signed [W-1:0]   a_re,
  input  wire logic signed [W-1:0]   a_im,
  input  wire logic signed [W-1:0]   b_re,
  input  wire logic signed [W-1:0]   b_im,
  output cau_pkg::flags_t            flags_r,
  output logic [W-1:0]               res_re_r,
  output logic [W-1:0]               res_im_r,
  output logic [2*W+F-1:0]           rem_re_r,
  output logic [2*W+F-1:0]           rem_im_r,
  output logic [2*W-1:0]             den_r
);

  localparam int AW = W + 1;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W + F;
  localparam int CW = 3 * W + F + 1;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // Stage A: products and plain sums.
  cau_pkg::mode_t          mode_a_r;
  logic signed [PW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, s_rr_r, s_ii_r;
  logic signed [AW-1:0]    as_re_r, as_im_r;
  logic signed [AW-1:0]    as_re_nxt, as_im_nxt;

  always_comb begin
    if (mode == cau_pkg::MODE_SUB) begin
      as_re_nxt = AW'(a_re) - AW'(b_re);
      as_im_nxt = AW'(a_im) - AW'(b_im);
    end else begin
      as_re_nxt = AW'(a_re) + AW'(b_re);
      as_im_nxt = AW'(a_im) + AW'(b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_a_r <= mode;
      p_rr_r   <= a_re * b_re;
      p_ii_r   <= a_im * b_im;
      p_ri_r   <= a_re * b_im;
      p_ir_r   <= a_im * b_re;
      s_rr_r   <= b_re * b_re;
      s_ii_r   <= b_im * b_im;
      as_re_r  <= as_re_nxt;
      as_im_r  <= as_im_nxt;
    end
  end

  // Stage B: pick the sum, or combine the products into one value per part.
  cau_pkg::mode_t          mode_b_r;
  logic signed [NW-1:0]    v_re_r, v_im_r, v_re_nxt, v_im_nxt;
  logic signed [NW-1:0]    mul_re, mul_im;
  logic [PW-1:0]           den_b_r, den_nxt;

  always_comb begin
    mul_re  = NW'(p_rr_r) - NW'(p_ii_r);
    mul_im  = NW'(p_ri_r) + NW'(p_ir_r);
    den_nxt = PW'($unsigned(s_rr_r)) + PW'($unsigned(s_ii_r));
    case (mode_a_r)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        v_re_nxt = NW'(as_re_r);
        v_im_nxt = NW'(as_im_r);
      end
      cau_pkg::MODE_MUL: begin
        // Arithmetic shift gives the floor of the scaled product.
        v_re_nxt = mul_re >>> F;
        v_im_nxt = mul_im >>> F;
      end
      cau_pkg::MODE_DIV: begin
        v_re_nxt = NW'(p_rr_r) + NW'(p_ii_r);
        v_im_nxt = NW'(p_ir_r) - NW'(p_ri_r);
      end
      default: begin
        v_re_nxt = '0;
        v_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode_b_r <= mode_a_r;
      v_re_r   <= v_re_nxt;
      v_im_r   <= v_im_nxt;
      den_b_r  <= den_nxt;
    end
  end

  // Stage C: saturate direct results, or set up the long division.
  function automatic logic [W:0] sat_word(input logic signed [NW-1:0] v);
    logic in_range;
    in_range = (&v[NW-1:W-1]) | ~(|v[NW-1:W-1]);
    if (in_range) begin
      sat_word = {1'b0, v[W-1:0]};
    end else begin
      sat_word = {1'b1, (v[NW-1] ? SMIN : SMAX)};
    end
  endfunction

  logic [W:0]              sat_re, sat_im;
  logic [PW-1:0]           mag_re, mag_im;
  logic [DW-1:0]           d_re, d_im;
  logic [CW-1:0]           den_top;
  cau_pkg::flags_t         flags_nxt;

  always_comb begin
    sat_re  = sat_word(v_re_r);
    sat_im  = sat_word(v_im_r);
    mag_re  = PW'(v_re_r[NW-1] ? -v_re_r : v_re_r);
    mag_im  = PW'(v_im_r[NW-1] ? -v_im_r : v_im_r);
    d_re    = DW'(mag_re) << F;
    d_im    = DW'(mag_im) << F;
    den_top = CW'(den_b_r) << (W + 1);
    flags_nxt.is_div   = (mode_b_r == cau_pkg::MODE_DIV);
    flags_nxt.dz       = (mode_b_r == cau_pkg::MODE_DIV) && (den_b_r == '0);
    flags_nxt.ovf      = sat_re[W] | sat_im[W];
    flags_nxt.neg_re   = v_re_r[NW-1];
    flags_nxt.neg_im   = v_im_r[NW-1];
    // A quotient of 2^(W+1) or more saturates whatever its low bits are.
    flags_nxt.clamp_re = CW'(d_re) >= den_top;
    flags_nxt.clamp_im = CW'(d_im) >= den_top;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      flags_r  <= flags_nxt;
      res_re_r <= sat_re[W-1:0];
      res_im_r <= sat_im[W-1:0];
      rem_re_r <= d_re;
      rem_im_r <= d_im;
      den_r    <= den_b_r;
    end
  end

endmodule

`default_nettype wire

FILE: design/cau_div_step.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One restoring division stage deciding quotient bit BIT for both parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int BIT = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire cau_pkg::flags_t   flags_in,
  input  wire logic [W-1:0]      res_re_in,
  input  wire logic [W-1:0]      res_im_in,
  input  wire logic [2*W+F-1:0]  rem_re_in,
  input  wire logic [2*W+F-1:0]  rem_im_in,
  input  wire logic [W:0]        q_re_in,
  input  wire logic [W:0]        q_im_in,
  input  wire logic [2*W-1:0]    den_in,
  output cau_pkg::flags_t        flags_r,
  output logic [W-1:0]           res_re_r,
  output logic [W-1:0]           res_im_r,
  output logic [2*W+F-1:0]       rem_re_r,
  output logic [2*W+F-1:0]       rem_im_r,
  output logic [W:0]             q_re_r,
  output logic [W:0]             q_im_r,
  output logic [2*W-1:0]         den_r
);

  localparam int DW = 2 * W + F;
  localparam int CW = 3 * W + F + 1;
  localparam int QW = W + 1;

  logic [CW-1:0] trial;
  logic          take_re, take_im;
  logic [DW-1:0] rem_re_nxt, rem_im_nxt;
  logic [QW-1:0] q_re_nxt, q_im_nxt;

  always_comb begin
    trial      = CW'(den_in) << BIT;
    take_re    = CW'(rem_re_in) >= trial;
    take_im    = CW'(rem_im_in) >= trial;
    rem_re_nxt = take_re ? DW'(CW'(rem_re_in) - trial) : rem_re_in;
    rem_im_nxt = take_im ? DW'(CW'(rem_im_in) - trial) : rem_im_in;
    q_re_nxt   = q_re_in | (take_re ? (QW'(1) << BIT) : '0);
    q_im_nxt   = q_im_in | (take_im ? (QW'(1) << BIT) : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r  <= flags_in;
      res_re_r <= res_re_in;
      res_im_r <= res_im_in;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      den_r    <= den_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/cau_out.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Passes direct results, applies sign and saturation to quotients and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_out #(
  parameter int W = 32
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire cau_pkg::flags_t                   flags,
  input  wire logic [W-1:0]                      res_re,
  input  wire logic [W-1:0]                      res_im,
  input  wire logic [W:0]                        q_re,
  input  wire logic [W:0]                        q_im,
  output logic [cau_pkg::FIELD_BITS-1:0]         res_real_r,
  output logic [cau_pkg::FIELD_BITS-1:0]         res_imag_r,
  output logic                                   overflow_r,
  output logic                                   div_by_zero_r
);

  localparam int QW = W + 1;
  localparam int FB = cau_pkg::FIELD_BITS;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] div_sat(input logic neg, input logic clamp,
                                         input logic [QW-1:0] q);
    logic [QW-1:0] lim;
    lim = QW'(1) << (W - 1);
    if (neg) begin
      if (clamp || (q > lim)) begin
        div_sat = {1'b1, SMIN};
      end else begin
        div_sat = {1'b0, W'(QW'(0) - q)};
      end
    end else begin
      if (clamp || (q > (lim - QW'(1)))) begin
        div_sat = {1'b1, SMAX};
      end else begin
        div_sat = {1'b0, q[W-1:0]};
      end
    end
  endfunction

  logic [W:0]   dre, dim;
  logic [W-1:0] fin_re, fin_im;
  logic         fin_ovf, fin_dz;

  always_comb begin
    dre = div_sat(flags.neg_re, flags.clamp_re, q_re);
    dim = div_sat(flags.neg_im, flags.clamp_im, q_im);
    if (!flags.is_div) begin
      fin_re  = res_re;
      fin_im  = res_im;
      fin_ovf = flags.ovf;
      fin_dz  = 1'b0;
    end else if (flags.dz) begin
      fin_re  = '0;
      fin_im  = '0;
      fin_ovf = 1'b0;
      fin_dz  = 1'b1;
    end else begin
      fin_re  = dre[W-1:0];
      fin_im  = dim[W-1:0];
      fin_ovf = dre[W] | dim[W];
      fin_dz  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_real_r    <= FB'($signed(fin_re));
      res_imag_r    <= FB'($signed(fin_im));
      overflow_r    <= fin_ovf;
      div_by_zero_r <= fin_dz;
    end
  end

endmodule

`default_nettype wire

FILE: verif/complex_arithmetic_unit_top_tb.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, subtract, multiply and divide transactions with random idling
// and stalls, and checks each result against a fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_result_t;

  class cplx_scoreboard;
    cplx_result_t pending_q[$];
    int errors;
    int checked;

    function logic [31:0] clamp32(wide_t v, inout logic ovf);
      if (v > wide_t'(32'sh7fffffff)) begin
        ovf = 1'b1;
        return 32'h7fffffff;
      end
      if (v < -wide_t'(64'sh80000000)) begin
        ovf = 1'b1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    // Scaled quotient truncated toward zero; huge quotients saturate anyway.
    function wide_t scaled_quot(wide_t num, logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag << 16) / den;
      if (q > 128'hffff_ffff_ffff_ffff) q = 128'hffff_ffff_ffff_ffff;
      return (num < 0) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function void note(cau_pkg::mode_t m, logic [31:0] ar, logic [31:0] ai,
                       logic [31:0] br, logic [31:0] bi);
      wide_t sar, sai, sbr, sbi, vr, vi;
      logic [127:0] den;
      cplx_result_t r;
      sar = $signed(ar);
      sai = $signed(ai);
      sbr = $signed(br);
      sbi = $signed(bi);
      r.ovf = 1'b0;
      r.dz  = 1'b0;
      vr = 0;
      vi = 0;
      case (m)
        cau_pkg::MODE_ADD: begin
          vr = sar + sbr;
          vi = sai + sbi;
        end
        cau_pkg::MODE_SUB: begin
          vr = sar - sbr;
          vi = sai - sbi;
        end
        cau_pkg::MODE_MUL: begin
          // Arithmetic shift floors toward minus infinity.
          vr = (sar * sbr - sai * sbi) >>> 16;
          vi = (sar * sbi + sai * sbr) >>> 16;
        end
        default: begin
          den = sbr * sbr + sbi * sbi;
          if (den == 0) begin
            r.dz = 1'b1;
          end else begin
            vr = scaled_quot(sar * sbr + sai * sbi, den);
            vi = scaled_quot(sai * sbr - sar * sbi, den);
          end
        end
      endcase
      r.re = clamp32(vr, r.ovf);
      r.im = clamp32(vi, r.ovf);
      pending_q.push_back(r);
    endfunction

    function void check(logic [31:0] re, logic [31:0] im, logic ovf, logic dz);
      cplx_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h ovf=%b dz=%b", $time, re, im, ovf, dz);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (re !== e.re) begin
        $display("%0t: res_real expected %h actual %h", $time, e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: res_imag expected %h actual %h", $time, e.im, im);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, dz);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [31:0] in_a_real, in_a_imag, in_b_real, in_b_imag;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_res_real, out_res_imag;
  logic        out_overflow, out_div_by_zero;

  cplx_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int sent;

  complex_arithmetic_unit_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_real(out_res_real), .out_res_imag(out_res_imag),
    .out_overflow(out_overflow), .out_div_by_zero(out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Operand values: full range, small magnitudes and the word extremes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h0;
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(cau_pkg::mode_t m, logic [31:0] ar, logic [31:0] ai,
                         logic [31:0] br, logic [31:0] bi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    do @(posedge clk); while (in_stall);
    sb.note(m, ar, ai, br, bi);
    sent++;
  endtask

  task automatic send_random(int n);
    logic [31:0] br, bi;
    repeat (n) begin
      br = pick_operand();
      bi = pick_operand();
      if ($urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_op(cau_pkg::mode_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
              br, bi);
    end
  endtask

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check(out_res_real, out_res_imag, out_overflow, out_div_by_zero);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int waited;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req  = 1'b0;
    sent      = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = cau_pkg::MODE_ADD;
    in_a_real = '0;
    in_a_imag = '0;
    in_b_real = '0;
    in_b_imag = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of every operation, rounding and division by zero.
    send_op(cau_pkg::MODE_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
    send_op(cau_pkg::MODE_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_op(cau_pkg::MODE_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
    send_op(cau_pkg::MODE_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
    send_op(cau_pkg::MODE_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_op(cau_pkg::MODE_SUB, 32'h00030000, 32'h00010000, 32'h00030000, 32'h00010000);
    send_op(cau_pkg::MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(cau_pkg::MODE_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_op(cau_pkg::MODE_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
    send_op(cau_pkg::MODE_MUL, 32'h00018000, 32'hfffe8000, 32'h00020000, 32'h00010000);
    send_op(cau_pkg::MODE_MUL, 32'h00000001, 32'h00000001, 32'h00000001, 32'hffffffff);
    send_op(cau_pkg::MODE_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
    send_op(cau_pkg::MODE_DIV, 32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00000000);
    send_op(cau_pkg::MODE_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h00000000);
    send_op(cau_pkg::MODE_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(cau_pkg::MODE_DIV, 32'h00010000, 32'h00000000, 32'h00030000, 32'h00000000);
    send_op(cau_pkg::MODE_DIV, 32'hffff0000, 32'h00010000, 32'h00000000, 32'h00030000);
    send_op(cau_pkg::MODE_DIV, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000001);
    send_op(cau_pkg::MODE_DIV, 32'h00050000, 32'hfffb0000, 32'h7fffffff, 32'h80000000);

    send_random(170);
    // The receiver holds off for a long stretch while items keep arriving.
    hold_req = 1'b1;
    send_idle_pct = 74;
    send_random(170);
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    send_random(170);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_random(170);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    $display("Sent %0d transactions over all four operations, %0d results checked,",
             sent, sb.checked);
    $display("with sender idling, receiver stalls and a long output hold-off.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_step.sv
design/cau_out.sv
design/complex_arithmetic_unit_top.sv
verif/complex_arithmetic_unit_top_tb.sv
